// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge out of reset
`define ZMK_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: lbl");

// consequent holds in the same cycle as the antecedent
`define ZMK_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// consequent holds in the cycle after the antecedent
`define ZMK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`else

`define ZMK_ASSERT_ALWAYS(lbl, expr)
`define ZMK_ASSERT_IMPLIES(lbl, ante, cons)
`define ZMK_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/zmk_pkg.sv
// types, constants and symbol tables of the multi-tap key decoder
`default_nettype none

package zmk_pkg;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [0:0] REG_TIMEOUT = 1'b0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd700;

	localparam logic [1:0] OP_KEY = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_TONE = 2'd2;
	localparam logic [1:0] OP_SOFT_RESET = 2'd3;

	localparam logic [1:0] STATUS_REPLACE = 2'd0;
	localparam logic [1:0] STATUS_NEW = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	localparam logic [3:0] KEY_STAR = 4'd10;
	localparam logic [3:0] KEY_NONE = 4'd15;

	localparam logic [2:0] TAP_MAX = 3'd5;
	localparam logic [2:0] TAP_FIRST = 3'd1;
	localparam logic [2:0] CYCLE_RESET = 3'd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  key;
		logic [15:0] base_symbol;
	} evt_t;

	typedef struct packed {
		logic [15:0] symbol;
		logic        symbol_valid;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic valid;
		logic full;
	} buf_stat_t;

	localparam logic [15:0] SYM_TABLE [0:10][0:4] = '{
		'{16'h3127, 16'h3128, 16'h3129, 16'h0000, 16'h0000},
		'{16'h3105, 16'h3106, 16'h3107, 16'h3108, 16'h0000},
		'{16'h3109, 16'h310A, 16'h310B, 16'h310C, 16'h0000},
		'{16'h310D, 16'h310E, 16'h310F, 16'h0000, 16'h0000},
		'{16'h3110, 16'h3111, 16'h3112, 16'h0000, 16'h0000},
		'{16'h3113, 16'h3114, 16'h3115, 16'h3116, 16'h0000},
		'{16'h3117, 16'h3118, 16'h3119, 16'h0000, 16'h0000},
		'{16'h311A, 16'h311B, 16'h311C, 16'h311D, 16'h0000},
		'{16'h311E, 16'h311F, 16'h3120, 16'h3121, 16'h0000},
		'{16'h3122, 16'h3123, 16'h3124, 16'h3125, 16'h3126},
		'{16'h0020, 16'h02CA, 16'h02C7, 16'h02CB, 16'h02D9}
	};

	localparam logic [2:0] CYCLE_TABLE [0:15] = '{
		3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4,
		3'd4, 3'd5, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
	};

	function automatic logic [15:0] sym_lookup(input logic [3:0] key, input logic [2:0] tap);
		logic [2:0] col;
		col = tap - TAP_FIRST;
		if (key <= KEY_STAR && tap >= TAP_FIRST && tap <= TAP_MAX) begin
			return SYM_TABLE[key][col];
		end
		return 16'h0000;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/zmk_res_buf.sv
// two-entry result buffer between the decoder and the result channel
`default_nettype none

module zmk_res_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire zmk_pkg::res_t    push_item,
	input  wire logic             pop,
	output zmk_pkg::res_t         head,
	output zmk_pkg::buf_stat_t    stat
);
	import zmk_pkg::*;

	logic [1:0] count_q;
	res_t       head_q;
	res_t       tail_q;
	logic       do_pop;

	assign do_pop = pop && (count_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, do_pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					head_q <= push_item;
				end else begin
					tail_q <= push_item;
				end
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= push_item;
				end else begin
					head_q <= tail_q;
					tail_q <= push_item;
				end
			end
			default: head_q <= head_q;
		endcase
	end

	assign head = head_q;
	assign stat.valid = (count_q != 2'd0);
	assign stat.full = (count_q == 2'd2);

endmodule

`default_nettype wire

// File: rtl/core/zhuyin_multitap_key_decoder.sv
// top level of the multi-tap zhuyin keypad decoder
//
// event channel (evt_valid, evt_ready, evt): one transaction per key press,
// timer tick, tone mark request or soft reset. a key press or a tone mark
// request gives one result transaction on the result channel (res_valid,
// res_ready, res); a tick or a soft reset gives none.
// each event is decoded in the cycle it is taken: the state registers and
// the result buffer load at that edge; results leave on res in order. while
// the buffer has room one event per cycle is taken, set by the single state
// update loop through the last key, tap and timer registers.
// a two-entry result buffer parts the channels: while res is stalled the
// block keeps taking events until both entries hold results, then
// evt_ready drops until the receiver takes one.
// apb port: timeout_ticks at byte address 0, pready always high.
// reset clears the state to no key, timed out, timer stopped, and loads
// timeout_ticks with 700; the result buffer is emptied.
`default_nettype none
`include "assert_macros.svh"

module zhuyin_multitap_key_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            evt_valid,
	output logic                                 evt_ready,
	input  wire zmk_pkg::evt_t                   evt,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output zmk_pkg::res_t                        res,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [zmk_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [zmk_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [zmk_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import zmk_pkg::*;

	logic [15:0] timeout_q;
	logic [3:0]  last_key_q;
	logic        timed_out_q;
	logic [2:0]  tap_q;
	logic [2:0]  cycle_q;
	logic [15:0] timer_q;
	logic        running_q;

	logic [3:0]  last_key_n;
	logic        timed_out_n;
	logic [2:0]  tap_n;
	logic [2:0]  cycle_n;
	logic [15:0] timer_n;
	logic        running_n;

	logic        accept;
	logic        push;
	res_t        res_n;
	logic [15:0] sym;
	logic [2:0]  tone_pos;
	logic [15:0] timer_inc;
	logic        reg_wr;

	buf_stat_t   buf_stat;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT);
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT)
		? {{(APB_DATA_W-16){1'b0}}, timeout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (reg_wr) begin
			timeout_q <= pwdata[15:0];
		end
	end

	assign evt_ready = !buf_stat.full;
	assign accept = evt_valid && evt_ready;
	assign timer_inc = timer_q + 16'd1;

	always_comb begin
		tone_pos = 3'd0;
		for (int i = 4; i >= 0; i--) begin
			if (SYM_TABLE[KEY_STAR][i] == evt.base_symbol) begin
				tone_pos = 3'(i + 1);
			end
		end
	end

	always_comb begin
		last_key_n = last_key_q;
		timed_out_n = timed_out_q;
		tap_n = tap_q;
		cycle_n = cycle_q;
		timer_n = timer_q;
		running_n = running_q;
		push = 1'b0;
		res_n.status = STATUS_NEW;
		sym = 16'h0000;
		unique case (evt.operation)
			OP_TICK: begin
				if (running_q) begin
					timer_n = timer_inc;
					if (timer_inc >= timeout_q) begin
						timed_out_n = 1'b1;
						running_n = 1'b0;
					end
				end
			end
			OP_SOFT_RESET: begin
				last_key_n = KEY_NONE;
				timed_out_n = 1'b1;
				tap_n = 3'd0;
				cycle_n = CYCLE_RESET;
			end
			OP_TONE: begin
				push = 1'b1;
				cycle_n = TAP_MAX;
				tap_n = (tone_pos == TAP_MAX) ? TAP_FIRST : tone_pos + 3'd1;
				res_n.status = (tone_pos != 3'd0) ? STATUS_REPLACE : STATUS_NEW;
				sym = sym_lookup(KEY_STAR, tap_n);
				last_key_n = KEY_STAR;
				timed_out_n = 1'b0;
			end
			default: begin
				push = 1'b1;
				timer_n = 16'd0;
				running_n = 1'b1;
				if (evt.key == last_key_q && !timed_out_q) begin
					if (cycle_q != 3'd0) begin
						tap_n = tap_q + 3'd1;
						if (tap_n > cycle_q) begin
							tap_n = TAP_FIRST;
						end
					end
					res_n.status = STATUS_REPLACE;
				end else if (evt.key == last_key_q) begin
					tap_n = TAP_FIRST;
					res_n.status = STATUS_NEW;
				end else begin
					tap_n = TAP_FIRST;
					cycle_n = CYCLE_TABLE[evt.key];
					res_n.status = (cycle_n != 3'd0) ? STATUS_NEW : STATUS_INVALID;
				end
				sym = sym_lookup(evt.key, tap_n);
				last_key_n = evt.key;
				timed_out_n = 1'b0;
			end
		endcase
		res_n.symbol = sym;
		res_n.symbol_valid = (sym != 16'h0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= KEY_NONE;
			timed_out_q <= 1'b1;
			tap_q <= 3'd0;
			cycle_q <= CYCLE_RESET;
			timer_q <= 16'd0;
			running_q <= 1'b0;
		end else if (accept) begin
			last_key_q <= last_key_n;
			timed_out_q <= timed_out_n;
			tap_q <= tap_n;
			cycle_q <= cycle_n;
			timer_q <= timer_n;
			running_q <= running_n;
		end
	end

	zmk_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && push),
		.push_item (res_n),
		.pop       (res_ready),
		.head      (res),
		.stat      (buf_stat)
	);

	assign res_valid = buf_stat.valid;

	`ZMK_ASSERT_ALWAYS(a_tap_range, (tap_q <= TAP_MAX) && (cycle_q <= TAP_MAX))
	`ZMK_ASSERT_IMPLIES(a_sym_flag, res_valid, res.symbol_valid == (res.symbol != 16'h0000))
	`ZMK_ASSERT_IMPLIES(a_stall_full, !evt_ready, res_valid)
	`ZMK_ASSERT_NEXT(a_key_starts_timer, accept && (evt.operation == OP_KEY), running_q && !timed_out_q)

endmodule

`default_nettype wire
